// ===== rtl/core/cpu8x_pkg.sv =====
// ============================================================================
// cpu8x_pkg
// Shared types and constants for the 8-bit CPU execute unit.
// ============================================================================
package cpu8x_pkg;

    // Operation codes
    localparam logic [5:0] OP_ADC = 6'd0;
    localparam logic [5:0] OP_SBC = 6'd1;
    localparam logic [5:0] OP_AND = 6'd2;
    localparam logic [5:0] OP_ORA = 6'd3;
    localparam logic [5:0] OP_EOR = 6'd4;
    localparam logic [5:0] OP_CMP = 6'd5;
    localparam logic [5:0] OP_CPX = 6'd6;
    localparam logic [5:0] OP_CPY = 6'd7;
    localparam logic [5:0] OP_BIT = 6'd8;
    localparam logic [5:0] OP_LDA = 6'd9;
    localparam logic [5:0] OP_LDX = 6'd10;
    localparam logic [5:0] OP_LDY = 6'd11;
    localparam logic [5:0] OP_STA = 6'd12;
    localparam logic [5:0] OP_STX = 6'd13;
    localparam logic [5:0] OP_STY = 6'd14;
    localparam logic [5:0] OP_ASL = 6'd15;
    localparam logic [5:0] OP_LSR = 6'd16;
    localparam logic [5:0] OP_ROL = 6'd17;
    localparam logic [5:0] OP_ROR = 6'd18;
    localparam logic [5:0] OP_INC = 6'd19;
    localparam logic [5:0] OP_DEC = 6'd20;
    localparam logic [5:0] OP_INX = 6'd21;
    localparam logic [5:0] OP_INY = 6'd22;
    localparam logic [5:0] OP_DEX = 6'd23;
    localparam logic [5:0] OP_DEY = 6'd24;
    localparam logic [5:0] OP_TAX = 6'd25;
    localparam logic [5:0] OP_TAY = 6'd26;
    localparam logic [5:0] OP_TXA = 6'd27;
    localparam logic [5:0] OP_TYA = 6'd28;
    localparam logic [5:0] OP_TSX = 6'd29;
    localparam logic [5:0] OP_TXS = 6'd30;
    localparam logic [5:0] OP_CLC = 6'd31;
    localparam logic [5:0] OP_SEC = 6'd32;
    localparam logic [5:0] OP_CLI = 6'd33;
    localparam logic [5:0] OP_SEI = 6'd34;
    localparam logic [5:0] OP_CLD = 6'd35;
    localparam logic [5:0] OP_SED = 6'd36;
    localparam logic [5:0] OP_CLV = 6'd37;
    localparam logic [5:0] OP_PHA = 6'd38;
    localparam logic [5:0] OP_PHP = 6'd39;
    localparam logic [5:0] OP_PLA = 6'd40;
    localparam logic [5:0] OP_PLP = 6'd41;
    localparam logic [5:0] OP_BCC = 6'd42;
    localparam logic [5:0] OP_BCS = 6'd43;
    localparam logic [5:0] OP_BEQ = 6'd44;
    localparam logic [5:0] OP_BNE = 6'd45;
    localparam logic [5:0] OP_BMI = 6'd46;
    localparam logic [5:0] OP_BPL = 6'd47;
    localparam logic [5:0] OP_BVC = 6'd48;
    localparam logic [5:0] OP_BVS = 6'd49;
    localparam logic [5:0] OP_NOP = 6'd50;

    // Stack actions
    localparam logic [1:0] STACK_NONE = 2'd0;
    localparam logic [1:0] STACK_PUSH = 2'd1;
    localparam logic [1:0] STACK_PULL = 2'd2;

    // Status bit positions: N V 1 B D I Z C
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_ONE = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    // Reset values
    localparam logic [7:0] SP_RESET = 8'hFD;
    localparam logic [7:0] STATUS_RESET = 8'h24;

    typedef struct packed {
        logic [5:0]  req_type;
        logic [7:0]  operand;
        logic [15:0] target_address;
        logic        on_accumulator;
    } in_word_t;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [1:0]  stack_op;
        logic [7:0]  stack_slot;
        logic        branch_taken;
        logic [7:0]  acc_out;
        logic [7:0]  index_x_out;
        logic [7:0]  index_y_out;
        logic [7:0]  status_out;
    } out_word_t;

endpackage

// ===== rtl/core/cpu_8bit_execute_unit.sv =====
// ============================================================================
// cpu_8bit_execute_unit
// Execute stage of an 8-bit CPU: one decoded operation per word.
// ============================================================================
// Usage:
//   s_ channel carries one decoded operation word (operation number, operand
//   byte, effective address, accumulator-target bit). m_ channel returns one
//   result word per operation: memory write, stack action, branch decision
//   and the A, X, Y and status registers after the operation.
//   The word is registered in the input register, then moves to the result
//   register when that register is empty or its word is being taken.
//   Throughput: one word per cycle while m_ready is high, set by the single
//   execute pass between the two registers; the architectural registers are
//   updated on the same edge that loads the result, so the next operation
//   sees them immediately.
//   Reset (aresetn low, synchronous): A, X, Y = 0, SP = 0xFD, P = 0x24, both
//   pipeline registers empty.
//   Stall: when m_ready is low the result is held; one more word can wait in
//   the input register, after that s_ready drops until the result is taken.
// ============================================================================
module cpu_8bit_execute_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cpu8x_pkg::in_word_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cpu8x_pkg::out_word_t  m_data
);

    // Input stage
    logic                  in_valid_reg, in_valid_next;
    cpu8x_pkg::in_word_t   in_data_reg;

    // Result stage
    logic                  out_valid_reg, out_valid_next;
    cpu8x_pkg::out_word_t  out_data_reg, out_data_next;

    // Architectural registers
    logic [7:0] acc_reg, acc_next;
    logic [7:0] idx_x_reg, idx_x_next;
    logic [7:0] idx_y_reg, idx_y_next;
    logic [7:0] sp_reg, sp_next;
    logic [7:0] status_reg, status_next;

    logic advance;

    // Execute temporaries
    logic [5:0] op;
    logic [7:0] opnd;
    logic       cin;
    logic [8:0] sum;
    logic [7:0] addend;
    logic [8:0] diff;
    logic [7:0] cmp_reg;
    logic [7:0] shift_src;
    logic [7:0] shift_val;
    logic       shift_c;
    logic [7:0] incdec;
    logic       we;
    logic       taken;
    logic [7:0] wdata;
    logic [1:0] sop;
    logic [7:0] slot;

    // N and Z from a byte, other flags kept
    function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        r = p;
        r[cpu8x_pkg::FLAG_N] = v[7];
        r[cpu8x_pkg::FLAG_Z] = (v == 8'h00);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Execute pass
    // ------------------------------------------------------------------
    always_comb begin
        op   = in_data_reg.req_type;
        opnd = in_data_reg.operand;
        cin  = status_reg[cpu8x_pkg::FLAG_C];

        // adder; SBC adds the inverted operand
        addend = (op == cpu8x_pkg::OP_SBC) ? ~opnd : opnd;
        sum    = {1'b0, acc_reg} + {1'b0, addend} + {8'h00, cin};

        // compare
        priority if (op == cpu8x_pkg::OP_CPX) begin
            cmp_reg = idx_x_reg;
        end else if (op == cpu8x_pkg::OP_CPY) begin
            cmp_reg = idx_y_reg;
        end else begin
            cmp_reg = acc_reg;
        end
        diff = {1'b0, cmp_reg} - {1'b0, opnd};

        // shifter
        shift_src = in_data_reg.on_accumulator ? acc_reg : opnd;
        unique case (op)
            cpu8x_pkg::OP_ASL: begin
                shift_val = {shift_src[6:0], 1'b0};
                shift_c   = shift_src[7];
            end
            cpu8x_pkg::OP_ROL: begin
                shift_val = {shift_src[6:0], cin};
                shift_c   = shift_src[7];
            end
            cpu8x_pkg::OP_ROR: begin
                shift_val = {cin, shift_src[7:1]};
                shift_c   = shift_src[0];
            end
            default: begin
                shift_val = {1'b0, shift_src[7:1]};
                shift_c   = shift_src[0];
            end
        endcase

        incdec = (op == cpu8x_pkg::OP_DEC) ? opnd - 8'd1 : opnd + 8'd1;

        acc_next    = acc_reg;
        idx_x_next  = idx_x_reg;
        idx_y_next  = idx_y_reg;
        sp_next     = sp_reg;
        status_next = status_reg;
        we    = 1'b0;
        taken = 1'b0;
        wdata = 8'h00;
        sop   = cpu8x_pkg::STACK_NONE;
        slot  = 8'h00;

        unique case (op)
            cpu8x_pkg::OP_ADC, cpu8x_pkg::OP_SBC: begin
                acc_next = sum[7:0];
                status_next = with_nz(status_reg, sum[7:0]);
                status_next[cpu8x_pkg::FLAG_C] = sum[8];
                status_next[cpu8x_pkg::FLAG_V] =
                    ~(acc_reg[7] ^ addend[7]) & (acc_reg[7] ^ sum[7]);
            end
            cpu8x_pkg::OP_AND: begin
                acc_next = acc_reg & opnd;
                status_next = with_nz(status_reg, acc_reg & opnd);
            end
            cpu8x_pkg::OP_ORA: begin
                acc_next = acc_reg | opnd;
                status_next = with_nz(status_reg, acc_reg | opnd);
            end
            cpu8x_pkg::OP_EOR: begin
                acc_next = acc_reg ^ opnd;
                status_next = with_nz(status_reg, acc_reg ^ opnd);
            end
            cpu8x_pkg::OP_CMP, cpu8x_pkg::OP_CPX, cpu8x_pkg::OP_CPY: begin
                status_next = with_nz(status_reg, diff[7:0]);
                status_next[cpu8x_pkg::FLAG_C] = ~diff[8];
            end
            cpu8x_pkg::OP_BIT: begin
                status_next[cpu8x_pkg::FLAG_N] = opnd[7];
                status_next[cpu8x_pkg::FLAG_V] = opnd[6];
                status_next[cpu8x_pkg::FLAG_Z] = ((acc_reg & opnd) == 8'h00);
            end
            cpu8x_pkg::OP_LDA: begin
                acc_next = opnd;
                status_next = with_nz(status_reg, opnd);
            end
            cpu8x_pkg::OP_LDX: begin
                idx_x_next = opnd;
                status_next = with_nz(status_reg, opnd);
            end
            cpu8x_pkg::OP_LDY: begin
                idx_y_next = opnd;
                status_next = with_nz(status_reg, opnd);
            end
            cpu8x_pkg::OP_STA: begin
                we = 1'b1;
                wdata = acc_reg;
            end
            cpu8x_pkg::OP_STX: begin
                we = 1'b1;
                wdata = idx_x_reg;
            end
            cpu8x_pkg::OP_STY: begin
                we = 1'b1;
                wdata = idx_y_reg;
            end
            cpu8x_pkg::OP_ASL, cpu8x_pkg::OP_LSR,
            cpu8x_pkg::OP_ROL, cpu8x_pkg::OP_ROR: begin
                status_next = with_nz(status_reg, shift_val);
                status_next[cpu8x_pkg::FLAG_C] = shift_c;
                if (in_data_reg.on_accumulator) begin
                    acc_next = shift_val;
                end else begin
                    we = 1'b1;
                    wdata = shift_val;
                end
            end
            cpu8x_pkg::OP_INC, cpu8x_pkg::OP_DEC: begin
                status_next = with_nz(status_reg, incdec);
                we = 1'b1;
                wdata = incdec;
            end
            cpu8x_pkg::OP_INX: begin
                idx_x_next = idx_x_reg + 8'd1;
                status_next = with_nz(status_reg, idx_x_reg + 8'd1);
            end
            cpu8x_pkg::OP_INY: begin
                idx_y_next = idx_y_reg + 8'd1;
                status_next = with_nz(status_reg, idx_y_reg + 8'd1);
            end
            cpu8x_pkg::OP_DEX: begin
                idx_x_next = idx_x_reg - 8'd1;
                status_next = with_nz(status_reg, idx_x_reg - 8'd1);
            end
            cpu8x_pkg::OP_DEY: begin
                idx_y_next = idx_y_reg - 8'd1;
                status_next = with_nz(status_reg, idx_y_reg - 8'd1);
            end
            cpu8x_pkg::OP_TAX: begin
                idx_x_next = acc_reg;
                status_next = with_nz(status_reg, acc_reg);
            end
            cpu8x_pkg::OP_TAY: begin
                idx_y_next = acc_reg;
                status_next = with_nz(status_reg, acc_reg);
            end
            cpu8x_pkg::OP_TXA: begin
                acc_next = idx_x_reg;
                status_next = with_nz(status_reg, idx_x_reg);
            end
            cpu8x_pkg::OP_TYA: begin
                acc_next = idx_y_reg;
                status_next = with_nz(status_reg, idx_y_reg);
            end
            cpu8x_pkg::OP_TSX: begin
                idx_x_next = sp_reg;
                status_next = with_nz(status_reg, sp_reg);
            end
            cpu8x_pkg::OP_TXS: begin
                sp_next = idx_x_reg;
            end
            cpu8x_pkg::OP_CLC: status_next[cpu8x_pkg::FLAG_C] = 1'b0;
            cpu8x_pkg::OP_SEC: status_next[cpu8x_pkg::FLAG_C] = 1'b1;
            cpu8x_pkg::OP_CLI: status_next[cpu8x_pkg::FLAG_I] = 1'b0;
            cpu8x_pkg::OP_SEI: status_next[cpu8x_pkg::FLAG_I] = 1'b1;
            cpu8x_pkg::OP_CLD: status_next[cpu8x_pkg::FLAG_D] = 1'b0;
            cpu8x_pkg::OP_SED: status_next[cpu8x_pkg::FLAG_D] = 1'b1;
            cpu8x_pkg::OP_CLV: status_next[cpu8x_pkg::FLAG_V] = 1'b0;
            cpu8x_pkg::OP_PHA: begin
                sop = cpu8x_pkg::STACK_PUSH;
                slot = sp_reg;
                wdata = acc_reg;
                sp_next = sp_reg - 8'd1;
            end
            cpu8x_pkg::OP_PHP: begin
                // B and the always-one bit are set in P, then P is pushed
                status_next[cpu8x_pkg::FLAG_B] = 1'b1;
                status_next[cpu8x_pkg::FLAG_ONE] = 1'b1;
                sop = cpu8x_pkg::STACK_PUSH;
                slot = sp_reg;
                wdata = status_next;
                sp_next = sp_reg - 8'd1;
            end
            cpu8x_pkg::OP_PLA: begin
                sp_next = sp_reg + 8'd1;
                sop = cpu8x_pkg::STACK_PULL;
                slot = sp_reg + 8'd1;
                acc_next = opnd;
                status_next = with_nz(status_reg, opnd);
            end
            cpu8x_pkg::OP_PLP: begin
                sp_next = sp_reg + 8'd1;
                sop = cpu8x_pkg::STACK_PULL;
                slot = sp_reg + 8'd1;
                status_next = opnd;
                status_next[cpu8x_pkg::FLAG_ONE] = 1'b1;
            end
            cpu8x_pkg::OP_BCC: taken = ~status_reg[cpu8x_pkg::FLAG_C];
            cpu8x_pkg::OP_BCS: taken =  status_reg[cpu8x_pkg::FLAG_C];
            cpu8x_pkg::OP_BEQ: taken =  status_reg[cpu8x_pkg::FLAG_Z];
            cpu8x_pkg::OP_BNE: taken = ~status_reg[cpu8x_pkg::FLAG_Z];
            cpu8x_pkg::OP_BMI: taken =  status_reg[cpu8x_pkg::FLAG_N];
            cpu8x_pkg::OP_BPL: taken = ~status_reg[cpu8x_pkg::FLAG_N];
            cpu8x_pkg::OP_BVC: taken = ~status_reg[cpu8x_pkg::FLAG_V];
            cpu8x_pkg::OP_BVS: taken =  status_reg[cpu8x_pkg::FLAG_V];
            // NOP and unused codes leave everything alone
            default: begin
            end
        endcase

        out_data_next.write_enable  = we;
        out_data_next.write_address = in_data_reg.target_address;
        out_data_next.write_data    = wdata;
        out_data_next.stack_op      = sop;
        out_data_next.stack_slot    = slot;
        out_data_next.branch_taken  = taken;
        out_data_next.acc_out       = acc_next;
        out_data_next.index_x_out   = idx_x_next;
        out_data_next.index_y_out   = idx_y_next;
        out_data_next.status_out    = status_next;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= 8'h00;
            idx_x_reg     <= 8'h00;
            idx_y_reg     <= 8'h00;
            sp_reg        <= cpu8x_pkg::SP_RESET;
            status_reg    <= cpu8x_pkg::STATUS_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                acc_reg    <= acc_next;
                idx_x_reg  <= idx_x_next;
                idx_y_reg  <= idx_y_next;
                sp_reg     <= sp_next;
                status_reg <= status_next;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_push_dec_sp: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_data_reg.req_type == cpu8x_pkg::OP_PHA ||
                    in_data_reg.req_type == cpu8x_pkg::OP_PHP)
        |=> sp_reg == $past(sp_reg) - 8'd1)
        else $error("push did not decrement stack pointer");

    a_branch_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.branch_taken
        |-> !m_data.write_enable && m_data.stack_op == cpu8x_pkg::STACK_NONE)
        else $error("taken branch with memory or stack action");

    a_status_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status_out[cpu8x_pkg::FLAG_ONE])
        else $error("status bit 5 cleared");

    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(advance) |-> m_data.acc_out == acc_reg && m_data.status_out == status_reg)
        else $error("result registers out of step with state");
`endif

endmodule
